// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle property");

`endif

// ===== src/fock2e_pkg.sv =====
// Package of the Fock two-electron accumulator: transaction types, item
// codes, weight codes and saturation limits. No dependencies.
`timescale 1ns / 1ps

package fock2e_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_INTEGRAL = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  // Weights held as twice their value.
  localparam logic signed [3:0] W2_NEG_ONE      = -4'sd2;
  localparam logic signed [3:0] W2_NEG_HALF     = -4'sd1;
  localparam logic signed [3:0] W2_HALF         = 4'sd1;
  localparam logic signed [3:0] W2_ONE          = 4'sd2;
  localparam logic signed [3:0] W2_THREE_HALVES = 4'sd3;
  localparam logic signed [3:0] W2_TWO          = 4'sd4;

  // Accumulator limits.
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         idx_p;
    logic [5:0]         idx_q;
    logic [5:0]         idx_r;
    logic [5:0]         idx_s;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] matrix_value;
    logic               saturated;
  } out_item_t;

  // One symmetry image of an integral.
  typedef struct packed {
    logic              en;
    logic [5:0]        row;
    logic [5:0]        col;
    logic [5:0]        drow;
    logic [5:0]        dcol;
    logic signed [3:0] w2;
  } term_t;

  // Stage enables of the shared multiply-accumulate unit.
  typedef struct packed {
    logic              mul_en;
    logic              scale_en;
    logic signed [3:0] w2;
  } mac_ctrl_t;

endpackage

// ===== src/fock2e_term_sel.sv =====
// Symmetry-image selector: maps the integral indices and a term number to
// the target cell, density cell and weight. Depends on fock2e_pkg.
`timescale 1ns / 1ps

module fock2e_term_sel (
  input  logic [5:0]          idx_p_i,
  input  logic [5:0]          idx_q_i,
  input  logic [5:0]          idx_r_i,
  input  logic [5:0]          idx_s_i,
  input  logic [2:0]          term_i,
  output fock2e_pkg::term_t   term_o
);

  // Twice the a-weight from the index-equality rules.
  function automatic logic signed [3:0] weight_a2(logic [5:0] i, logic [5:0] j,
                                                  logic [5:0] k, logic [5:0] l);
    logic signed [3:0] w;
    if ((k == i || k == j) && l == k) begin
      w = fock2e_pkg::W2_HALF;
    end else if (j != i && (k == i || k == j || l == i || l == j) && l != k) begin
      w = fock2e_pkg::W2_THREE_HALVES;
    end else if (k != i && k != j && l != i && l != j && l != k) begin
      w = fock2e_pkg::W2_TWO;
    end else begin
      w = fock2e_pkg::W2_ONE;
    end
    return w;
  endfunction

  // Twice the b-weight from the index-equality rules.
  function automatic logic signed [3:0] weight_b2(logic [5:0] i, logic [5:0] j,
                                                  logic [5:0] k, logic [5:0] l);
    logic signed [3:0] w;
    if (k == i && k != j && l != i && l != j) begin
      w = fock2e_pkg::W2_NEG_ONE;
    end else if ((j == i || k == j) && l == j) begin
      w = fock2e_pkg::W2_HALF;
    end else if (k == i && (k == j || l == i) && l != j) begin
      w = fock2e_pkg::W2_ONE;
    end else if (k != i && (k == j || l == i) && l != j) begin
      w = fock2e_pkg::W2_THREE_HALVES;
    end else begin
      w = fock2e_pkg::W2_NEG_HALF;
    end
    return w;
  endfunction

  logic [5:0] p, q, r, s;

  assign p = idx_p_i;
  assign q = idx_q_i;
  assign r = idx_r_i;
  assign s = idx_s_i;

  // Each term number selects one image and its enabling condition.
  always_comb begin
    unique case (term_i)
      3'd0: term_o = '{1'b1, p, q, r, s, weight_a2(p, q, r, s)};
      3'd1: term_o = '{(r != q), p, r, q, s, weight_b2(p, q, r, s)};
      3'd2: term_o = '{(s != q && s != r), p, s, q, r, weight_b2(p, q, s, r)};
      3'd3: term_o = '{(q >= r && q != p), q, r, p, s, weight_b2(q, p, r, s)};
      3'd4: term_o = '{(q < r && r != p), r, q, p, s, weight_b2(r, s, q, p)};
      3'd5: term_o = '{(q >= s && s != r && q != p), q, s, p, r, weight_b2(q, p, s, r)};
      3'd6: term_o = '{(q < s && s != r), s, q, p, r, weight_b2(s, r, q, p)};
      default: term_o = '{(r != p && r != q && s != q), r, s, p, q, weight_a2(r, s, p, q)};
    endcase
  end

endmodule

// ===== src/fock2e_mac.sv =====
// Shared multiply-scale-accumulate unit with a saturating 64-bit adder.
// Depends on fock2e_pkg.
`timescale 1ns / 1ps

module fock2e_mac (
  input  logic                    clk_i,
  input  fock2e_pkg::mac_ctrl_t   ctrl_i,
  input  logic signed [31:0]      dens_i,
  input  logic signed [31:0]      value_i,
  input  logic signed [63:0]      acc_i,
  output logic signed [63:0]      sum_o,
  output logic                    clip_o
);

  logic signed [63:0] product_d, product_q;
  logic signed [66:0] scaled_d, scaled_q;
  logic signed [64:0] term_val;
  logic signed [66:0] term_ext;
  logic signed [3:0]  mag4;
  logic [2:0]         mag;
  logic               neg;
  logic signed [67:0] sum_wide;
  logic               in_range;

  // Stage one: exact product of density and integral value.
  assign product_d = dens_i * value_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      product_q <= product_d;
    end
  end

  // Stage two: signed weight magnitude applied by shift and add.
  assign neg      = ctrl_i.w2 < 0;
  assign mag4     = neg ? -ctrl_i.w2 : ctrl_i.w2;
  assign mag      = mag4[2:0];
  assign term_val = neg ? -65'(product_q) : 65'(product_q);
  assign term_ext = 67'(term_val);

  always_comb begin
    unique case (mag)
      3'd1:    scaled_d = term_ext;
      3'd2:    scaled_d = term_ext <<< 1;
      3'd3:    scaled_d = term_ext + (term_ext <<< 1);
      3'd4:    scaled_d = term_ext <<< 2;
      default: scaled_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scale_en) begin
      scaled_q <= scaled_d;
    end
  end

  // Final stage: exact sum, clipped to the signed 64-bit range.
  assign sum_wide = 68'(acc_i) + 68'(scaled_q);
  assign in_range = (&sum_wide[67:63]) || !(|sum_wide[67:63]);
  assign clip_o   = !in_range;
  assign sum_o    = in_range ? sum_wide[63:0]
                  : (sum_wide[67] ? fock2e_pkg::ACC_MIN : fock2e_pkg::ACC_MAX);

endmodule

// ===== src/fock_two_electron_accumulator.sv =====
// Top level of the Fock two-electron accumulator: sequencer, density and
// accumulator memories. Depends on fock2e_pkg, fock2e_term_sel, fock2e_mac.
//
// Usage: items enter on the in channel (in_valid_i/in_ready_o, in_item_i)
// and read results leave on the out channel (out_valid_o/out_ready_i,
// out_item_o). Only a read item yields a transaction on the out channel.
// Items are handled one at a time; in_ready_o is high only when the
// sequencer is idle.
// A density load is written at acceptance; the sequencer stays idle.
// A read fetches its accumulator entry at acceptance, then waits in ST_READ
// until the output register is free and loads its result there.
// An integral walks its eight symmetry images through the shared
// multiply-accumulate unit: an active image passes ST_T_SEL (memory
// read), ST_T_MUL (multiply), ST_T_SCALE (weight scale) and ST_T_ADD
// (saturating add and write back), an inactive one only ST_T_SEL. The
// first image is always active and of each mirrored pair at most one
// is, so an in-range integral has one to six active images, walked in
// turn through the single-port accumulator memory and one shared multiplier.
// A clear item sweeps the accumulator one entry a cycle, all BASIS_SIZE^2
// entries. The same sweep runs after reset, so in_ready_o stays low after
// rst_ni rises until the sweep is done.
// While the receiver stalls, the result holds in the output register;
// loads, clears and integrals are still taken, and a further read waits.
`timescale 1ns / 1ps

module fock_two_electron_accumulator #(
  parameter int BASIS_SIZE = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fock2e_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output fock2e_pkg::out_item_t  out_item_o
);

  localparam int CELLS  = BASIS_SIZE * BASIS_SIZE;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_T_SEL   = 3'd3;
  localparam logic [2:0] ST_T_MUL   = 3'd4;
  localparam logic [2:0] ST_T_SCALE = 3'd5;
  localparam logic [2:0] ST_T_ADD   = 3'd6;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [5:0] row, logic [5:0] col);
    return ADDR_W'(32'(row) * 32'(BASIS_SIZE) + 32'(col));
  endfunction

  function automatic logic idx_ok(logic [5:0] idx);
    return 32'(idx) < 32'(BASIS_SIZE);
  endfunction

  logic [2:0]            state_q, state_d;
  fock2e_pkg::in_item_t  item_q;
  logic [2:0]            term_cnt_q, term_cnt_d;
  logic [ADDR_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic                  clip_q, clip_d;
  fock2e_pkg::term_t     term_q, term_sel;
  logic                  rd_zero_q;
  logic                  out_valid_q, out_valid_d;
  fock2e_pkg::out_item_t out_item_q;

  logic                  accept, slot_free, pq_ok, all_ok;
  logic [5:0]            rd_hi, rd_lo;

  logic                  dens_we, dens_re;
  logic [ADDR_W-1:0]     dens_addr;
  logic signed [31:0]    dens_rdata_q;
  logic                  acc_we, acc_re;
  logic [ADDR_W-1:0]     acc_addr;
  logic signed [63:0]    acc_wdata, acc_rdata_q;

  logic signed [31:0]    dens_mem [CELLS];
  logic signed [63:0]    acc_mem  [CELLS];

  fock2e_pkg::mac_ctrl_t mac_ctrl;
  logic signed [63:0]    mac_sum;
  logic                  mac_clip;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign pq_ok      = idx_ok(in_item_i.idx_p) && idx_ok(in_item_i.idx_q);
  assign all_ok     = pq_ok && idx_ok(in_item_i.idx_r) && idx_ok(in_item_i.idx_s);
  assign rd_hi      = (in_item_i.idx_p > in_item_i.idx_q) ? in_item_i.idx_p : in_item_i.idx_q;
  assign rd_lo      = (in_item_i.idx_p > in_item_i.idx_q) ? in_item_i.idx_q : in_item_i.idx_p;

  // Image selection for the current term number.
  fock2e_term_sel u_term_sel (
    .idx_p_i (item_q.idx_p),
    .idx_q_i (item_q.idx_q),
    .idx_r_i (item_q.idx_r),
    .idx_s_i (item_q.idx_s),
    .term_i  (term_cnt_q),
    .term_o  (term_sel)
  );

  // Shared arithmetic unit.
  assign mac_ctrl.mul_en   = (state_q == ST_T_MUL);
  assign mac_ctrl.scale_en = (state_q == ST_T_SCALE);
  assign mac_ctrl.w2       = term_q.w2;

  fock2e_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .dens_i  (dens_rdata_q),
    .value_i (item_q.value_in),
    .acc_i   (acc_rdata_q),
    .sum_o   (mac_sum),
    .clip_o  (mac_clip)
  );

  // Sequencer and memory port control.
  always_comb begin
    state_d     = state_q;
    term_cnt_d  = term_cnt_q;
    clr_cnt_d   = clr_cnt_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dens_we     = 1'b0;
    dens_re     = 1'b0;
    dens_addr   = cell_addr(term_sel.drow, term_sel.dcol);
    acc_we      = 1'b0;
    acc_re      = 1'b0;
    acc_addr    = cell_addr(term_sel.row, term_sel.col);
    acc_wdata   = mac_sum;
    unique case (state_q)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_addr  = clr_cnt_q;
        acc_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.kind)
            fock2e_pkg::KIND_LOAD: begin
              dens_we   = pq_ok;
              dens_addr = cell_addr(in_item_i.idx_p, in_item_i.idx_q);
            end
            fock2e_pkg::KIND_INTEGRAL: begin
              term_cnt_d = '0;
              if (all_ok) begin
                state_d = ST_T_SEL;
              end
            end
            fock2e_pkg::KIND_READ: begin
              acc_re   = pq_ok;
              acc_addr = cell_addr(rd_hi, rd_lo);
              state_d  = ST_READ;
            end
            default: begin
              clip_d    = 1'b0;
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_T_SEL: begin
        if (term_sel.en) begin
          dens_re = 1'b1;
          acc_re  = 1'b1;
          state_d = ST_T_MUL;
        end else begin
          term_cnt_d = term_cnt_q + 1'b1;
          if (term_cnt_q == 3'd7) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_T_MUL: begin
        state_d = ST_T_SCALE;
      end
      ST_T_SCALE: begin
        state_d = ST_T_ADD;
      end
      ST_T_ADD: begin
        acc_we     = 1'b1;
        acc_addr   = cell_addr(term_q.row, term_q.col);
        clip_d     = clip_q || mac_clip;
        term_cnt_d = term_cnt_q + 1'b1;
        state_d    = (term_cnt_q == 3'd7) ? ST_IDLE : ST_T_SEL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; the accumulator sweep starts out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      term_cnt_q  <= '0;
      clr_cnt_q   <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_cnt_q  <= term_cnt_d;
      clr_cnt_q   <= clr_cnt_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q    <= in_item_i;
      rd_zero_q <= !pq_ok;
    end
    if (state_q == ST_T_SEL) begin
      term_q <= term_sel;
    end
    if (state_q == ST_READ && slot_free) begin
      out_item_q.matrix_value <= rd_zero_q ? '0 : acc_rdata_q;
      out_item_q.saturated    <= clip_q;
    end
  end

  // Density memory, single port.
  always_ff @(posedge clk_i) begin
    if (dens_we) begin
      dens_mem[dens_addr] <= in_item_i.value_in;
    end else if (dens_re) begin
      dens_rdata_q <= dens_mem[dens_addr];
    end
  end

  // Accumulator memory, single port.
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end else if (acc_re) begin
      acc_rdata_q <= acc_mem[acc_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/fock2e_checker.sv =====
// Port-level checker for the Fock two-electron accumulator, bound to the
// top level. Depends on fock2e_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fock2e_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input fock2e_pkg::in_item_t   in_item_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input fock2e_pkg::out_item_t  out_item_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_item_o))

  // A clear or a read occupies the block for at least the following cycle.
  `ASSERT_NEXT(a_clear_busy, clk_i, rst_ni, in_acc && in_item_i.kind == fock2e_pkg::KIND_CLEAR, !in_ready_o)
  `ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_acc && in_item_i.kind == fock2e_pkg::KIND_READ, !in_ready_o)

  // A density load leaves the block ready in the following cycle.
  `ASSERT_NEXT(a_load_done, clk_i, rst_ni, in_acc && in_item_i.kind == fock2e_pkg::KIND_LOAD, in_ready_o)

endmodule

bind fock_two_electron_accumulator fock2e_checker u_fock2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the Fock two-electron accumulator.
// It predicts each read result from its own copy of density and accumulator state.
// Depends on fock2e_pkg and fock_two_electron_accumulator.
`timescale 1ns / 1ps

// Predicts the accumulator and compares read results in order.
class fock_scoreboard;
  localparam int N = 64;
  longint density[N*N];
  longint accum[N*N];
  bit clip;
  fock2e_pkg::out_item_t pending_reads[$];
  int errors;

  function new();
    foreach (accum[i]) accum[i] = 0;
    foreach (density[i]) density[i] = 0;
    clip = 0;
    errors = 0;
  endfunction

  // Twice the coulomb-type weight.
  function int coul_w2(int i, int j, int k, int l);
    if ((k == i || k == j) && l == k) return 1;
    if (j != i && (k == i || k == j || l == i || l == j) && l != k) return 3;
    if (k != i && k != j && l != i && l != j && l != k) return 4;
    return 2;
  endfunction

  // Twice the exchange-type weight.
  function int exch_w2(int i, int j, int k, int l);
    if (k == i && k != j && l != i && l != j) return -2;
    if ((j == i || k == j) && l == j) return 1;
    if (k == i && (k == j || l == i) && l != j) return 2;
    if (k != i && (k == j || l == i) && l != j) return 3;
    return -1;
  endfunction

  function longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) + 65'(signed'(b));
    if (s > 65'(fock2e_pkg::ACC_MAX)) begin
      clip = 1;
      return fock2e_pkg::ACC_MAX;
    end
    if (s < 65'(fock2e_pkg::ACC_MIN)) begin
      clip = 1;
      return fock2e_pkg::ACC_MIN;
    end
    return longint'(s[63:0]);
  endfunction

  // One symmetry image: twice the weight times density times integral value.
  function void add_image(int row, int col, int w2, int dr, int dc, longint v);
    longint prod, t;
    int n;
    prod = density[dr*N+dc] * v;
    t = (w2 < 0) ? -prod : prod;
    n = (w2 < 0) ? -w2 : w2;
    for (int k = 0; k < n; k++) accum[row*N+col] = sat_sum(accum[row*N+col], t);
  endfunction

  // Updates the prediction for an accepted transaction.
  function void note_input(fock2e_pkg::in_item_t it);
    int p, q, r, s;
    longint v;
    fock2e_pkg::out_item_t res;
    p = it.idx_p; q = it.idx_q; r = it.idx_r; s = it.idx_s;
    v = longint'(it.value_in);
    case (it.kind)
      fock2e_pkg::KIND_LOAD: density[p*N+q] = v;
      fock2e_pkg::KIND_CLEAR: begin
        foreach (accum[i]) accum[i] = 0;
        clip = 0;
      end
      fock2e_pkg::KIND_READ: begin
        res.matrix_value = (p > q) ? accum[p*N+q] : accum[q*N+p];
        res.saturated = clip;
        pending_reads.push_back(res);
      end
      default: begin
        add_image(p, q, coul_w2(p, q, r, s), r, s, v);
        if (r != q) add_image(p, r, exch_w2(p, q, r, s), q, s, v);
        if (s != q && s != r) add_image(p, s, exch_w2(p, q, s, r), q, r, v);
        if (q >= r && q != p) add_image(q, r, exch_w2(q, p, r, s), p, s, v);
        if (q < r && r != p) add_image(r, q, exch_w2(r, s, q, p), p, s, v);
        if (q >= s && s != r && q != p) add_image(q, s, exch_w2(q, p, s, r), p, r, v);
        if (q < s && s != r) add_image(s, q, exch_w2(s, r, q, p), p, r, v);
        if (r != p && r != q && s != q) add_image(r, s, coul_w2(r, s, p, q), p, q, v);
      end
    endcase
  endfunction

  // Compares a result transaction with the oldest expected read.
  function void check_result(fock2e_pkg::out_item_t got);
    fock2e_pkg::out_item_t exp_r;
    if (pending_reads.size() == 0) begin
      $error("unexpected result: matrix_value %0d", got.matrix_value);
      errors++;
      return;
    end
    exp_r = pending_reads.pop_front();
    if (got.matrix_value !== exp_r.matrix_value) begin
      $error("matrix_value: expected %0d, got %0d", exp_r.matrix_value, got.matrix_value);
      errors++;
    end
    if (got.saturated !== exp_r.saturated) begin
      $error("saturated: expected %0b, got %0b", exp_r.saturated, got.saturated);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int N = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_ITEMS = 1500;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  fock2e_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  fock2e_pkg::out_item_t out_item_o;

  fock_scoreboard sb = new();
  bit density_loaded[N*N];
  int items_sent = 0;
  bit no_gaps = 0;
  bit hold_request = 0;
  int idle_cycles = 0;

  fock_two_electron_accumulator #(.BASIS_SIZE(N)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Monitors both channels and keeps the idle watchdog.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_input(in_item_i);
    if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Offers one transaction and waits for it to be taken.
  task automatic send(logic [1:0] k, int p, int q, int r, int s, logic signed [31:0] v);
    int g;
    in_valid_i <= 1;
    in_item_i <= '{kind: k, idx_p: 6'(p), idx_q: 6'(q), idx_r: 6'(r), idx_s: 6'(s),
                   value_in: v};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (k == fock2e_pkg::KIND_LOAD) density_loaded[p*N+q] = 1;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic load_if_missing(int a, int b);
    if (!density_loaded[a*N+b]) begin
      send(fock2e_pkg::KIND_LOAD, a, b, $urandom, $urandom, pick_value());
    end
  endtask

  // Integral with every density entry it may touch loaded beforehand.
  task automatic send_integral(int p, int q, int r, int s, logic signed [31:0] v);
    load_if_missing(r, s);
    load_if_missing(q, s);
    load_if_missing(q, r);
    load_if_missing(p, s);
    load_if_missing(p, r);
    load_if_missing(p, q);
    send(fock2e_pkg::KIND_INTEGRAL, p, q, r, s, v);
  endtask

  // Receiver: random stalls, and long hold-offs on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_request = 0;
      end else if (no_gaps) begin
        out_ready_i <= 1;
      end else if ($urandom_range(0, 99) < 3) begin
        out_ready_i <= 0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    int p, q, r, s, pick;
    int pool[4];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;

    // Directed part: saturation on repeated equal-index images, extremes, patterns.
    send(fock2e_pkg::KIND_LOAD, 0, 0, 0, 0, 32'sh7FFF_FFFF);
    repeat (3) send_integral(0, 0, 0, 0, 32'sh7FFF_FFFF);
    send(fock2e_pkg::KIND_READ, 0, 0, 0, 0, 0);
    send(fock2e_pkg::KIND_LOAD, 63, 63, 0, 0, 32'sh8000_0000);
    send_integral(63, 63, 63, 63, 32'sh8000_0000);
    send(fock2e_pkg::KIND_READ, 63, 63, 0, 0, 0);
    send(fock2e_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
    send(fock2e_pkg::KIND_READ, 0, 0, 0, 0, 0);
    send_integral(1, 2, 3, 4, 32'sd16777216);
    send_integral(5, 5, 6, 7, -32'sd3);
    send_integral(8, 9, 10, 10, 32'sd12345);
    send_integral(11, 12, 11, 13, -32'sd777);
    send_integral(14, 15, 16, 15, 32'sd99);
    send(fock2e_pkg::KIND_READ, 2, 1, 0, 0, 0);
    send(fock2e_pkg::KIND_READ, 1, 2, 0, 0, 0);
    send(fock2e_pkg::KIND_READ, 63, 0, 0, 0, 0);

    // Random part: mostly integrals and reads on a small index pool.
    while (items_sent < NUM_ITEMS) begin
      if (items_sent > 400 && items_sent < 600) no_gaps = 1;
      else no_gaps = 0;
      if (items_sent > 800 && items_sent < 810) hold_request = 1;
      if ($urandom_range(0, 19) == 0) foreach (pool[i]) pool[i] = $urandom_range(0, N-1);
      p = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : $urandom_range(0, N-1);
      q = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : $urandom_range(0, N-1);
      r = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : $urandom_range(0, N-1);
      s = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : $urandom_range(0, N-1);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_integral(p, q, r, s, pick_value());
      end else if (pick < 82) begin
        send(fock2e_pkg::KIND_READ, p, q, $urandom, $urandom, $urandom);
      end else if (pick < 98) begin
        send(fock2e_pkg::KIND_LOAD, p, q, $urandom, $urandom, pick_value());
      end else begin
        send(fock2e_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
    in_valid_i <= 0;

    wait (sb.pending_reads.size() == 0);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
